// File: src/modexp_pkg.sv
package modexp_pkg;

   localparam int FIELD_W   = 64;
   localparam int OPERAND_W = 64;
   localparam int CNT_W     = $clog2(OPERAND_W + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS  = CSR_IDX_W'(1);

   typedef logic [OPERAND_W-1:0] operand_type;

   typedef struct packed {
      logic        start;
      operand_type a;
      operand_type b;
      operand_type m;
   } mm_req_type;

   typedef struct packed {
      logic        done;
      operand_type product;
   } mm_rsp_type;

endpackage

// File: src/modexp_mulmod.sv
module modexp_mulmod (
   input  logic                   clock,
   input  logic                   reset,
   input  modexp_pkg::mm_req_type mm_req,
   output modexp_pkg::mm_rsp_type mm_rsp
);
   import modexp_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   operand_type       r_ff, r_in;
   operand_type       a_ff, a_in;
   operand_type       b_ff, b_in;
   operand_type       m_ff, m_in;

   logic [OPERAND_W:0] dbl;
   logic [OPERAND_W:0] dbl_sub;
   operand_type        dbl_mod;
   logic [OPERAND_W:0] sum;
   logic [OPERAND_W:0] sum_sub;
   operand_type        step_mod;

   // One bit of the multiplier per cycle: r = 2r mod m, then r = r + a mod m if the bit is set.
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_sub = dbl - {1'b0, m_ff};
      dbl_mod = (dbl >= {1'b0, m_ff}) ? dbl_sub[OPERAND_W-1:0] : dbl[OPERAND_W-1:0];
      sum     = {1'b0, dbl_mod} + {1'b0, a_ff};
      sum_sub = sum - {1'b0, m_ff};
      if (b_ff[OPERAND_W-1]) begin
         step_mod = (sum >= {1'b0, m_ff}) ? sum_sub[OPERAND_W-1:0] : sum[OPERAND_W-1:0];
      end else begin
         step_mod = dbl_mod;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      if (mm_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(OPERAND_W);
         r_in    = '0;
         a_in    = mm_req.a;
         b_in    = mm_req.b;
         m_in    = mm_req.m;
      end else if (busy_ff) begin
         r_in   = step_mod;
         b_in   = {b_ff[OPERAND_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff <= r_in;
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
   end

   assign mm_rsp.done    = done_ff;
   assign mm_rsp.product = r_ff;

endmodule

// File: src/modular_exponentiation_unit.sv
// Channel   Direction  Payload
// req_      in         tdata = base_value
// rsp_      out        tdata = power_result, tuser = modulus_error
// csr_      in         index 0 = exponent_value, index 1 = modulus_value
//
// Each item runs on one shared bit-serial modular multiplier: one product reduces
// the base, then one square per exponent bit below the leading one and one extra
// product per set bit below it, after a scan of the exponent bits from the top
// down to the leading one. A zero modulus or exponent skips the multiplier and goes
// straight to the result.
// Reset is synchronous and sets both registers to 1. req_tready is high only while idle.
// A finished result waits in the output register, and the next item is taken meanwhile.
module modular_exponentiation_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [modexp_pkg::FIELD_W-1:0]      req_tdata,   // [63:0] base_value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [modexp_pkg::FIELD_W-1:0]      rsp_tdata,   // [63:0] power_result
   output logic                                rsp_tuser,   // [0] modulus_error
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [modexp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [modexp_pkg::FIELD_W-1:0]      csr_data
);
   import modexp_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_NEXT   = 3'd3;
   localparam logic [2:0] ST_SQUARE = 3'd4;
   localparam logic [2:0] ST_MULT   = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   localparam operand_type ONE = OPERAND_W'(1);

   logic [2:0]         state_ff, state_in;
   logic [FIELD_W-1:0] exp_ff, exp_in;
   logic [FIELD_W-1:0] mod_ff, mod_in;
   operand_type        e_sh_ff, e_sh_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   operand_type        bred_ff, bred_in;
   operand_type        acc_ff, acc_in;
   logic               err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_err_ff, rsp_err_in;

   operand_type        e_op;
   operand_type        m_op;
   operand_type        base_op;
   mm_req_type         mm_req;
   mm_rsp_type         mm_rsp;

   modexp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   assign e_op    = exp_ff[OPERAND_W-1:0];
   assign m_op    = mod_ff[OPERAND_W-1:0];
   assign base_op = req_tdata[OPERAND_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      exp_in = exp_ff;
      mod_in = mod_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXPONENT: exp_in = csr_data;
            CSR_MODULUS:  mod_in = csr_data;
            default:      ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      e_sh_in      = e_sh_ff;
      cnt_in       = cnt_ff;
      bred_in      = bred_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      mm_req       = '0;
      mm_req.m     = m_op;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               err_in = 1'b0;
               if (m_op == '0) begin
                  acc_in   = '0;
                  err_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (e_op == '0) begin
                  acc_in   = ONE;
                  state_in = ST_FINISH;
               end else begin
                  // The base is reduced as the product (1 mod m) * base.
                  mm_req.start = 1'b1;
                  mm_req.a     = (m_op == ONE) ? '0 : ONE;
                  mm_req.b     = base_op;
                  e_sh_in      = e_op;
                  cnt_in       = CNT_W'(OPERAND_W);
                  state_in     = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_rsp.done) begin
               bred_in  = mm_rsp.product;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            e_sh_in = {e_sh_ff[OPERAND_W-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (e_sh_ff[OPERAND_W-1]) begin
               acc_in   = bred_ff;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               mm_req.start = 1'b1;
               mm_req.a     = acc_ff;
               mm_req.b     = acc_ff;
               state_in     = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.product;
               if (e_sh_ff[OPERAND_W-1]) begin
                  mm_req.start = 1'b1;
                  mm_req.a     = mm_rsp.product;
                  mm_req.b     = bred_ff;
                  state_in     = ST_MULT;
               end else begin
                  e_sh_in  = {e_sh_ff[OPERAND_W-2:0], 1'b0};
                  cnt_in   = cnt_ff - CNT_W'(1);
                  state_in = ST_NEXT;
               end
            end
         end
         ST_MULT: begin
            if (mm_rsp.done) begin
               acc_in   = mm_rsp.product;
               e_sh_in  = {e_sh_ff[OPERAND_W-2:0], 1'b0};
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_NEXT;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = FIELD_W'(acc_ff);
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exp_ff       <= FIELD_W'(1);
         mod_ff       <= FIELD_W'(1);
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      e_sh_ff     <= e_sh_in;
      bred_ff     <= bred_in;
      acc_ff      <= acc_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
